### sv/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// Shared types, register codes and the B,C cubic coefficient table (x18).
// ----------------------------------------------------------------------------
package cci_pkg;

    localparam int FRACTION_BITS_DEF = 12;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int VALUE_W           = 16;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 16;
    localparam int COEF_W            = 7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE   = 1'd1;

    // kernel modes
    localparam logic [1:0] MODE_HERMITE     = 2'd0;
    localparam logic [1:0] MODE_BSPLINE     = 2'd1;
    localparam logic [1:0] MODE_MITCHELL    = 2'd2;
    localparam logic [1:0] MODE_CATMULL_ROM = 2'd3;

    localparam logic [1:0]         KERNEL_MODE_RESET = MODE_MITCHELL;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET   = 16'd255;

    // polynomial rows: row 0 multiplies t^3, row 3 is the constant term
    localparam logic [1:0] ROW_T3 = 2'd0;
    localparam logic [1:0] ROW_T2 = 2'd1;
    localparam logic [1:0] ROW_T1 = 2'd2;
    localparam logic [1:0] ROW_T0 = 2'd3;

    // four taps of one row, tap i in element i (before, left, right, after)
    typedef logic [3:0][COEF_W-1:0] coef_row_t;

    // load enables of a two-stage multiply-accumulate slice
    typedef struct packed {
        logic load_mul;
        logic load_sum;
    } step_en_t;

    function automatic coef_row_t coef_row(input logic [1:0] mode, input logic [1:0] row);
        coef_row_t c;
        c = '0;
        unique case ({mode, row})
            {MODE_HERMITE, ROW_T3}:     c = {7'sd0, -7'sd36, 7'sd36, 7'sd0};
            {MODE_HERMITE, ROW_T2}:     c = {7'sd0, 7'sd54, -7'sd54, 7'sd0};
            {MODE_HERMITE, ROW_T1}:     c = {7'sd0, 7'sd0, 7'sd0, 7'sd0};
            {MODE_HERMITE, ROW_T0}:     c = {7'sd0, 7'sd0, 7'sd18, 7'sd0};
            {MODE_BSPLINE, ROW_T3}:     c = {7'sd3, -7'sd9, 7'sd9, -7'sd3};
            {MODE_BSPLINE, ROW_T2}:     c = {7'sd0, 7'sd9, -7'sd18, 7'sd9};
            {MODE_BSPLINE, ROW_T1}:     c = {7'sd0, 7'sd9, 7'sd0, -7'sd9};
            {MODE_BSPLINE, ROW_T0}:     c = {7'sd0, 7'sd3, 7'sd12, 7'sd3};
            {MODE_MITCHELL, ROW_T3}:    c = {7'sd7, -7'sd21, 7'sd21, -7'sd7};
            {MODE_MITCHELL, ROW_T2}:    c = {-7'sd6, 7'sd27, -7'sd36, 7'sd15};
            {MODE_MITCHELL, ROW_T1}:    c = {7'sd0, 7'sd9, 7'sd0, -7'sd9};
            {MODE_MITCHELL, ROW_T0}:    c = {7'sd0, 7'sd1, 7'sd16, 7'sd1};
            {MODE_CATMULL_ROM, ROW_T3}: c = {7'sd9, -7'sd27, 7'sd27, -7'sd9};
            {MODE_CATMULL_ROM, ROW_T2}: c = {-7'sd9, 7'sd36, -7'sd45, 7'sd18};
            {MODE_CATMULL_ROM, ROW_T1}: c = {7'sd0, 7'sd9, 7'sd0, -7'sd9};
            {MODE_CATMULL_ROM, ROW_T0}: c = {7'sd0, 7'sd0, 7'sd18, 7'sd0};
            default:                    c = '0;
        endcase
        return c;
    endfunction

endpackage

### sv/cci_horner_step.sv
// ----------------------------------------------------------------------------
// cci_horner_step
// One Horner step acc*f + (row << ROW_SHIFT), split into two half-width
// partial products in the first stage and summed in the second.
// ----------------------------------------------------------------------------
module cci_horner_step #(
    parameter int ACC_W     = 37,
    parameter int FRAC_W    = 12,
    parameter int ROW_W     = 24,
    parameter int ROW_SHIFT = 24
) (
    input  logic                        aclk,
    input  cci_pkg::step_en_t           en,
    input  logic signed [ACC_W-1:0]     acc_in,
    input  logic [FRAC_W-1:0]           frac_in,
    input  logic signed [ROW_W-1:0]     row_in,
    output logic signed [ACC_W+FRAC_W:0] acc_out
);

    localparam int LO_W  = ACC_W / 2;
    localparam int HI_W  = ACC_W - LO_W;
    localparam int OUT_W = ACC_W + FRAC_W + 1;
    localparam int PL_W  = LO_W + FRAC_W;
    localparam int PH_W  = HI_W + FRAC_W + 1;

    logic [PL_W-1:0]         pl_reg, pl_next;
    logic signed [PH_W-1:0]  ph_reg, ph_next;
    logic signed [ROW_W-1:0] row_reg;
    logic [OUT_W-1:0]        acc_reg, acc_next;

    // low half is unsigned, high half carries the sign
    assign pl_next = acc_in[LO_W-1:0] * frac_in;
    assign ph_next = $signed(acc_in[ACC_W-1:LO_W]) * $signed({1'b0, frac_in});

    assign acc_next = {ph_reg, {LO_W{1'b0}}}
                    + {{(OUT_W-PL_W){1'b0}}, pl_reg}
                    + {{(OUT_W-ROW_W-ROW_SHIFT){row_reg[ROW_W-1]}}, row_reg,
                       {ROW_SHIFT{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en.load_mul) begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            row_reg <= row_in;
        end
        if (en.load_sum) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = $signed(acc_reg);

endmodule

### sv/cubic_convolution_interpolator.sv
// Throughput: one item per cycle while m_tready is high; nine register stages each hold one item.
// Stage depth is set by the Horner multiplies (split in half-width partial
// products) and the reciprocal multiply for the divide by 18.
// Reset clears all stage valid bits and loads kernel_mode = Mitchell and
// max_value = 255.
// ----------------------------------------------------------------------------
// cubic_convolution_interpolator
// Mitchell-Netravali B,C cubic interpolation of four samples at a fraction,
// exact integer evaluation, round half up, clamp to 0..max_value.
// ----------------------------------------------------------------------------
module cubic_convolution_interpolator #(
    parameter int FRACTION_BITS = cci_pkg::FRACTION_BITS_DEF,
    parameter int SAMPLE_BITS   = cci_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration
    input  logic                                     cfg_wen,
    input  logic [cci_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [cci_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    // input stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // fraction, sample_before, sample_left, sample_right, sample_after
    input  logic [((FRACTION_BITS+4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // value
    output logic [cci_pkg::VALUE_W-1:0]              m_tdata,
    // clipped
    output logic                                     m_tuser
);

    localparam int F   = FRACTION_BITS;
    localparam int S   = SAMPLE_BITS;
    localparam int NS  = 9;
    localparam int RW  = S + 8;
    localparam int SUMW = RW + 3;
    localparam int A1W = RW + F + 1;
    localparam int A2W = A1W + F + 1;
    localparam int A3W = A2W + F + 1;
    localparam int XW  = A3W - 3 * F;
    localparam int MW  = XW + 1;
    localparam int QW  = XW - 4;
    localparam int VW  = cci_pkg::VALUE_W;
    localparam int CW  = (QW > VW) ? QW : VW;

    localparam logic [A3W:0] HALF  = (A3W+1)'(9) << (3 * F);
    // floor(x/18) = (x*M) >> (XW+5) for every x below 2^XW
    localparam logic [63:0]  DIV_M = (64'd1 << (XW + 5)) / 64'd18 + 64'd1;
    localparam logic [MW-1:0] DIV_MUL = DIV_M[MW-1:0];

    // ---------------- configuration ----------------
    logic [1:0]    kernel_mode_reg;
    logic [VW-1:0] max_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode_reg <= cci_pkg::KERNEL_MODE_RESET;
            max_value_reg   <= cci_pkg::MAX_VALUE_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                cci_pkg::REG_KERNEL_MODE: kernel_mode_reg <= cfg_wdata[1:0];
                cci_pkg::REG_MAX_VALUE:   max_value_reg   <= cfg_wdata[VW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage control ----------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;

    // a stage loads when empty or when the one after it moves
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];

    // ---------------- stage 0: coefficient rows ----------------
    logic [F-1:0]          frac_in;
    logic [S-1:0]          sample_in [4];
    logic signed [RW-1:0]  row_next [4];
    logic signed [RW-1:0]  row_reg [4];
    logic [F-1:0]          frac0_reg;

    assign frac_in = s_tdata[F-1:0];

    always_comb begin
        cci_pkg::coef_row_t   taps;
        logic signed [SUMW-1:0] dot;
        for (int i = 0; i < 4; i++) begin
            sample_in[i] = s_tdata[F + S * i +: S];
        end
        for (int r = 0; r < 4; r++) begin
            taps = cci_pkg::coef_row(kernel_mode_reg, 2'(r));
            dot  = '0;
            for (int i = 0; i < 4; i++) begin
                dot = dot + $signed(taps[i]) * $signed({1'b0, sample_in[i]});
            end
            row_next[r] = dot[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int r = 0; r < 4; r++) begin
                row_reg[r] <= row_next[r];
            end
            frac0_reg <= frac_in;
        end
    end

    // ---------------- stage 1: first Horner step ----------------
    logic signed [A1W-1:0] acc1_next, acc1_reg;
    logic [F-1:0]          frac1_reg, frac2_reg, frac3_reg;
    logic signed [RW-1:0]  row2_d1_reg;
    logic signed [RW-1:0]  row3_d1_reg, row3_d2_reg, row3_d3_reg;

    assign acc1_next = row_reg[0] * $signed({1'b0, frac0_reg})
                     + $signed({row_reg[1][RW-1], row_reg[1], {F{1'b0}}});

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            acc1_reg    <= acc1_next;
            frac1_reg   <= frac0_reg;
            row2_d1_reg <= row_reg[2];
            row3_d1_reg <= row_reg[3];
        end
        if (stage_en[2]) begin
            frac2_reg   <= frac1_reg;
            row3_d2_reg <= row3_d1_reg;
        end
        if (stage_en[3]) begin
            frac3_reg   <= frac2_reg;
            row3_d3_reg <= row3_d2_reg;
        end
    end

    // ---------------- stages 2..5: second and third Horner steps ----------------
    cci_pkg::step_en_t     step2_en, step3_en;
    logic signed [A2W-1:0] acc2;
    logic signed [A3W-1:0] acc3;

    assign step2_en = '{load_mul: stage_en[2], load_sum: stage_en[3]};
    assign step3_en = '{load_mul: stage_en[4], load_sum: stage_en[5]};

    cci_horner_step #(
        .ACC_W     (A1W),
        .FRAC_W    (F),
        .ROW_W     (RW),
        .ROW_SHIFT (2 * F)
    ) u_step2 (
        .aclk    (aclk),
        .en      (step2_en),
        .acc_in  (acc1_reg),
        .frac_in (frac1_reg),
        .row_in  (row2_d1_reg),
        .acc_out (acc2)
    );

    cci_horner_step #(
        .ACC_W     (A2W),
        .FRAC_W    (F),
        .ROW_W     (RW),
        .ROW_SHIFT (3 * F)
    ) u_step3 (
        .aclk    (aclk),
        .en      (step3_en),
        .acc_in  (acc2),
        .frac_in (frac3_reg),
        .row_in  (row3_d3_reg),
        .acc_out (acc3)
    );

    // ---------------- stage 6: round half up ----------------
    logic [A3W:0]    rnd_sum;
    logic            neg6_reg, neg7_reg;
    logic [XW-1:0]   x_reg;

    assign rnd_sum = {acc3[A3W-1], acc3} + HALF;

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            neg6_reg <= rnd_sum[A3W];
            x_reg    <= rnd_sum[A3W-1:3*F];
        end
    end

    // ---------------- stage 7: divide by 18 ----------------
    logic [XW+MW-1:0] quot_prod;
    logic [QW-1:0]    q_reg;

    assign quot_prod = x_reg * DIV_MUL;

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            q_reg    <= quot_prod[XW+MW-1:XW+5];
            neg7_reg <= neg6_reg;
        end
    end

    // ---------------- stage 8: clamp ----------------
    logic [CW-1:0] q_ext, max_ext;
    logic [VW-1:0] value_reg, value_next;
    logic          clipped_reg, clipped_next;

    assign q_ext   = CW'(q_reg);
    assign max_ext = CW'(max_value_reg);

    always_comb begin
        if (neg7_reg) begin
            value_next   = '0;
            clipped_next = 1'b1;
        end else if (q_ext > max_ext) begin
            value_next   = max_value_reg;
            clipped_next = 1'b1;
        end else begin
            value_next   = q_ext[VW-1:0];
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            value_reg   <= value_next;
            clipped_reg <= clipped_next;
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = value_reg;
    assign m_tuser  = clipped_reg;

    // ---------------- assertions ----------------
    a_accept_fills_stage0: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted transfer did not reach stage 0");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_tready)
        else $error("input stalled with empty first stage");

    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0 || m_tdata == max_value_reg))
        else $error("clipped result not at a range limit");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata <= max_value_reg))
        else $error("unclipped result above max_value");

endmodule
